// ===== sv/mcapt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcapt_pkg
// Shared types and constants of the multichannel analyzer with preset timer.
// ----------------------------------------------------------------------------
package mcapt_pkg;

	localparam int CHANNELS_DEF = 4096;

	localparam int CH_W    = 12;
	localparam int CNT_W   = 16;
	localparam int KIND_W  = 3;
	localparam int DATA_W  = 32;
	localparam int DEAD_W  = 20;
	localparam int CFG_I_W = 2;
	localparam int FRAC_W  = 16;
	// channel widened far enough to address the largest spectrum
	localparam int CH_EXT_W = 17;

	localparam logic [KIND_W-1:0] KIND_COUNT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TICK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_START = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STOP  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

	localparam logic [CFG_I_W-1:0] REG_REAL_TGT = 2'd0;
	localparam logic [CFG_I_W-1:0] REG_LIVE_TGT = 2'd1;
	localparam logic [CFG_I_W-1:0] REG_DEAD     = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CH_W-1:0]   channel;
		logic [CNT_W-1:0]  event_count;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] bin_count;
		logic [DATA_W-1:0] total_counts;
		logic [DATA_W-1:0] real_time_ms;
		logic [DATA_W-1:0] live_time_ms;
		logic              running;
		logic              preset_stop;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_LIVE,
		ST_CHK
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic sweep;
		logic mul;
		logic live;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic is_clear;
	} ctl_stat_t;

endpackage

// ===== sv/mcapt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcapt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcapt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/mcapt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcapt_ctrl
// Sequencer: walks each item through read, update, multiply, live time and
// preset check, and runs the zeroing sweep after reset and on clear.
// ----------------------------------------------------------------------------
module mcapt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mcapt_pkg::ctl_stat_t stat,
	output mcapt_pkg::ctl_cmd_t  cmd,
	output logic                busy
);

	import mcapt_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_SWEEP && stat.sweep_last) begin
				init_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (stat.sweep_last) begin
					state_nxt = init_q ? ST_IDLE : ST_MUL;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_RD;
				end
			end
			ST_RD: begin
				state_nxt = stat.is_clear ? ST_SWEEP : ST_MUL;
			end
			ST_MUL:  state_nxt = ST_LIVE;
			ST_LIVE: state_nxt = ST_CHK;
			ST_CHK:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_SWEEP: cmd.sweep = 1'b1;
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_RD:   cmd.exec   = 1'b1;
			ST_MUL:  cmd.mul    = 1'b1;
			ST_LIVE: cmd.live   = 1'b1;
			ST_CHK:  cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== sv/mcapt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcapt_dp
// Datapath: spectrum memory, totals, real time, live time arithmetic,
// preset registers and the result register.
// ----------------------------------------------------------------------------
module mcapt_dp #(
	parameter int CHANNELS = mcapt_pkg::CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mcapt_pkg::ctl_cmd_t                  cmd,
	output mcapt_pkg::ctl_stat_t                 stat,
	input  mcapt_pkg::in_item_t                  item,
	input  logic                                 cfg_we,
	input  logic [mcapt_pkg::CFG_I_W-1:0]        cfg_index,
	input  logic [mcapt_pkg::DATA_W-1:0]         cfg_data,
	output logic                                 result_valid,
	output mcapt_pkg::out_item_t                 result
);

	import mcapt_pkg::*;

	localparam int AW = $clog2(CHANNELS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);
	localparam int PROD_W = DATA_W + DEAD_W;

	in_item_t            item_q;
	logic [DATA_W-1:0]   total_q;
	logic [DATA_W-1:0]   real_q;
	logic                acq_q;
	logic [DATA_W-1:0]   rt_tgt_q;
	logic [DATA_W-1:0]   lt_tgt_q;
	logic [DEAD_W-1:0]   dead_q;
	logic [PROD_W-1:0]   prod_q;
	logic [DATA_W-1:0]   live_q;
	logic [DATA_W-1:0]   bin_q;
	logic [AW-1:0]       sweep_cnt_q;
	out_item_t           res_q;
	logic                res_valid_q;

	logic [CH_EXT_W-1:0] in_ch_ext;
	logic [CH_EXT_W-1:0] q_ch_ext;
	logic                ch_ok;
	logic [AW-1:0]       q_addr;
	logic [DATA_W-1:0]   rdata;
	logic [DATA_W:0]     bin_sum;
	logic [DATA_W-1:0]   bin_new;
	logic [DATA_W:0]     tot_sum;
	logic [DATA_W-1:0]   tot_new;
	logic                bin_upd;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic [PROD_W-1:0]   real_fx;
	logic [PROD_W-1:0]   live_diff;
	logic [DATA_W-1:0]   live_nxt;
	logic                stop;

	assign in_ch_ext = {(CH_EXT_W - CH_W)'(0), item.channel};
	assign q_ch_ext  = {(CH_EXT_W - CH_W)'(0), item_q.channel};
	assign ch_ok     = q_ch_ext < CH_EXT_W'(CHANNELS);
	assign q_addr    = q_ch_ext[AW-1:0];

	// saturating adds for the bin and the total
	assign bin_sum = {1'b0, rdata} + {(DATA_W + 1 - CNT_W)'(0), item_q.event_count};
	assign bin_new = bin_sum[DATA_W] ? '1 : bin_sum[DATA_W-1:0];
	assign tot_sum = {1'b0, total_q} + {(DATA_W + 1 - CNT_W)'(0), item_q.event_count};
	assign tot_new = tot_sum[DATA_W] ? '1 : tot_sum[DATA_W-1:0];

	assign bin_upd   = cmd.exec && item_q.kind == KIND_COUNT && acq_q && ch_ok;
	assign ram_we    = cmd.sweep || bin_upd;
	assign ram_waddr = cmd.sweep ? sweep_cnt_q : q_addr;
	assign ram_wdata = cmd.sweep ? '0 : bin_new;

	mcapt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CHANNELS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(in_ch_ext[AW-1:0]),
		.rdata(rdata)
	);

	assign stat.sweep_last = sweep_cnt_q == LAST_ADDR;
	assign stat.is_clear   = item_q.kind == KIND_CLEAR;

	// live = floor(real - total * dead / 2^16), clamped at zero
	assign real_fx   = {(PROD_W - DATA_W - FRAC_W)'(0), real_q, FRAC_W'(0)};
	assign live_diff = real_fx - prod_q;
	assign live_nxt  = (real_q == '0 || prod_q >= real_fx) ? '0
		: live_diff[FRAC_W +: DATA_W];

	assign stop = acq_q && ((rt_tgt_q != '0 && real_q >= rt_tgt_q)
		|| (lt_tgt_q != '0 && live_q >= lt_tgt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			real_q      <= '0;
			acq_q       <= 1'b0;
			rt_tgt_q    <= '0;
			lt_tgt_q    <= '0;
			dead_q      <= '0;
			sweep_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.finish;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_REAL_TGT: rt_tgt_q <= cfg_data;
					REG_LIVE_TGT: lt_tgt_q <= cfg_data;
					REG_DEAD:     dead_q   <= cfg_data[DEAD_W-1:0];
					default:      ;
				endcase
			end
			if (cmd.sweep) begin
				sweep_cnt_q <= stat.sweep_last ? '0 : sweep_cnt_q + AW'(1);
			end
			if (cmd.exec) begin
				unique case (item_q.kind)
					KIND_COUNT: begin
						if (acq_q && ch_ok) begin
							total_q <= tot_new;
						end
					end
					KIND_TICK: begin
						if (acq_q && real_q != '1) begin
							real_q <= real_q + DATA_W'(1);
						end
					end
					KIND_START: acq_q <= 1'b1;
					KIND_STOP:  acq_q <= 1'b0;
					KIND_CLEAR: begin
						total_q     <= '0;
						real_q      <= '0;
						sweep_cnt_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.finish) begin
				// drop acquisition when a preset is reached
				acq_q <= acq_q && !stop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			unique case (item_q.kind)
				KIND_COUNT: bin_q <= !ch_ok ? '0 : (acq_q ? bin_new : rdata);
				KIND_READ:  bin_q <= ch_ok ? rdata : '0;
				default:    bin_q <= '0;
			endcase
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(total_q) * PROD_W'(dead_q);
		end
		if (cmd.live) begin
			live_q <= live_nxt;
		end
		if (cmd.finish) begin
			res_q.bin_count    <= bin_q;
			res_q.total_counts <= total_q;
			res_q.real_time_ms <= real_q;
			res_q.live_time_ms <= live_q;
			res_q.running      <= acq_q && !stop;
			res_q.preset_stop  <= stop;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== sv/multichannel_analyzer_preset_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_analyzer_preset_timer
// Spectrum histogram with preset real and live time stop.
// ----------------------------------------------------------------------------
// channel   handshake               payload
// item      start in, busy out      item   (kind, channel, event_count)
// result    result_valid strobe     result (bins, totals, times, flags)
// config    cfg_we                  cfg_index, cfg_data
//
// An item is accepted when start is high and busy low and passes the RD,
// MUL, LIVE and CHK states; its result, registered from CHK, strobes for
// one cycle, and the next item may be accepted at the edge ending the
// strobe. The receiver cannot stall. A clear adds the one-entry-per-cycle
// bin-memory zeroing sweep after RD; it also holds busy high after reset.
// ----------------------------------------------------------------------------
module multichannel_analyzer_preset_timer #(
	parameter int CHANNELS = mcapt_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  mcapt_pkg::in_item_t           item,
	input  logic                          cfg_we,
	input  logic [mcapt_pkg::CFG_I_W-1:0] cfg_index,
	input  logic [mcapt_pkg::DATA_W-1:0]  cfg_data,
	output logic                          result_valid,
	output mcapt_pkg::out_item_t          result
);

	import mcapt_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	mcapt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	mcapt_dp #(
		.CHANNELS(CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item        (item),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.exec, cmd.sweep, cmd.mul, cmd.live, cmd.finish}))
		else $error("more than one sequencer command active");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not make the block busy");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without an item in flight");

	a_stop_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.preset_stop) |-> !result.running)
		else $error("preset stop reported while still running");
`endif

endmodule
